/* rtl/bpfa_pkg.sv */
// Shared types and constants for the bitmap page frame allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package bpfa_pkg;

  // Bitmap memory word and counter widths
  localparam int WORD_W     = 64;
  localparam int WORD_SH    = 6;
  localparam int CNT_W      = 16;
  localparam int PADDR_W    = 27;
  localparam int ADDR_W     = 32;

  // Default geometry
  localparam int DEF_PAGE_BYTES = 4096;
  localparam int DEF_PAGE_COUNT = 32768;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_RELEASE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OOM     = 2'd1,
    ST_IGNORED = 2'd2
  } stat_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_READ,
    S_WAIT,
    S_WRITE,
    S_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the input item
    logic setup;     // decode range, set pointer, apply release counts
    logic rd;        // read bitmap word at pointer
    logic proc;      // build modified word from read data
    logic wr;        // write modified word, update counters
    logic clr;       // write all-ones word at pointer (reset sweep)
    logic inc;       // advance word pointer
    logic res_load;  // copy result into output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;  // pointer at last word of the sweep
    logic skip;      // no bitmap work for this item
    logic last;      // pointer at last word of the range
    logic stop;      // alloc found a free page
  } sts_t;

endpackage

/* rtl/bitmap_page_frame_allocator.sv */
// Top level of the bitmap page frame allocator.
// Depends on bpfa_pkg, bpfa_ctrl and bpfa_datapath.
//
//   channel  dir  handshake              payload
//   in       in   in_valid_i/in_stall_o  op_i, address_i, range_end_i
//   out      out  out_valid_o/out_stall_i status_o, page_address_o,
//                                        free_count_o, total_count_o
//
// One item at a time: capture and setup, then a read, modify and write step for
// each 64-bit bitmap word visited through the single bitmap memory, then a step
// to hand over the result. Alloc visits words until the first free page, free
// one word, reserve and release the words that cover the range.
// After reset a sweep of all ceil(PAGE_COUNT/64) words marks every page used;
// input is stalled during it. A stalled result holds the block in its final
// step; the next item is taken as soon as the result sits in the output register.
module bitmap_page_frame_allocator #(
  parameter int PAGE_BYTES = bpfa_pkg::DEF_PAGE_BYTES,
  parameter int PAGE_COUNT = bpfa_pkg::DEF_PAGE_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    op_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]   address_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]   range_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [bpfa_pkg::PADDR_W-1:0]  page_address_o,
  output logic [bpfa_pkg::CNT_W-1:0]    free_count_o,
  output logic [bpfa_pkg::CNT_W-1:0]    total_count_o
);

  bpfa_pkg::cmd_t cmd;
  bpfa_pkg::sts_t sts;

  bpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bpfa_datapath #(
    .PAGE_BYTES (PAGE_BYTES),
    .PAGE_COUNT (PAGE_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .address_i      (address_i),
    .range_end_i    (range_end_i),
    .status_o       (status_o),
    .page_address_o (page_address_o),
    .free_count_o   (free_count_o),
    .total_count_o  (total_count_o)
  );

endmodule

/* rtl/bpfa_ctrl.sv */
// Sequencer for the bitmap page frame allocator.
// Depends on bpfa_pkg; drives bpfa_datapath through cmd_t and reads sts_t.
module bpfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  bpfa_pkg::sts_t sts_i,
  output bpfa_pkg::cmd_t cmd_o
);

  bpfa_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bpfa_pkg::S_CLEAR: if (sts_i.clr_last) state_d = bpfa_pkg::S_IDLE;
      bpfa_pkg::S_IDLE:  if (in_valid_i) state_d = bpfa_pkg::S_SETUP;
      bpfa_pkg::S_SETUP: state_d = sts_i.skip ? bpfa_pkg::S_DONE : bpfa_pkg::S_READ;
      bpfa_pkg::S_READ:  state_d = bpfa_pkg::S_WAIT;
      bpfa_pkg::S_WAIT:  state_d = bpfa_pkg::S_WRITE;
      bpfa_pkg::S_WRITE: begin
        state_d = (sts_i.stop || sts_i.last) ? bpfa_pkg::S_DONE : bpfa_pkg::S_READ;
      end
      bpfa_pkg::S_DONE:  if (slot_free) state_d = bpfa_pkg::S_IDLE;
      default:           state_d = bpfa_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      bpfa_pkg::S_CLEAR: begin
        cmd_o.clr = 1'b1;
        cmd_o.inc = 1'b1;
      end
      bpfa_pkg::S_IDLE:  cmd_o.load = in_valid_i;
      bpfa_pkg::S_SETUP: cmd_o.setup = 1'b1;
      bpfa_pkg::S_READ:  cmd_o.rd = 1'b1;
      bpfa_pkg::S_WAIT:  cmd_o.proc = 1'b1;
      bpfa_pkg::S_WRITE: begin
        cmd_o.wr  = 1'b1;
        cmd_o.inc = !(sts_i.stop || sts_i.last);
      end
      bpfa_pkg::S_DONE:  cmd_o.res_load = slot_free;
      default:           cmd_o = '0;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.res_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bpfa_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != bpfa_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/bpfa_datapath.sv */
// Bitmap memory, range decode, word modify and page counters.
// Depends on bpfa_pkg; commanded by bpfa_ctrl.
module bpfa_datapath #(
  parameter int PAGE_BYTES = bpfa_pkg::DEF_PAGE_BYTES,
  parameter int PAGE_COUNT = bpfa_pkg::DEF_PAGE_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpfa_pkg::cmd_t                cmd_i,
  output bpfa_pkg::sts_t                sts_o,
  input  logic [1:0]                    op_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]   address_i,
  input  logic [bpfa_pkg::ADDR_W-1:0]   range_end_i,
  output logic [1:0]                    status_o,
  output logic [bpfa_pkg::PADDR_W-1:0]  page_address_o,
  output logic [bpfa_pkg::CNT_W-1:0]    free_count_o,
  output logic [bpfa_pkg::CNT_W-1:0]    total_count_o
);

  localparam int WW  = bpfa_pkg::WORD_W;
  localparam int WS  = bpfa_pkg::WORD_SH;
  localparam int CW  = bpfa_pkg::CNT_W;
  localparam int AW  = bpfa_pkg::ADDR_W;
  localparam int SH  = $clog2(PAGE_BYTES);
  localparam int NW  = (PAGE_COUNT + WW - 1) / WW;
  localparam int WAW = (NW > 1) ? $clog2(NW) : 1;
  localparam int PW  = $clog2(PAGE_COUNT + 1);
  localparam int IW  = $clog2(PAGE_COUNT);
  localparam int EW  = (PW + SH > AW + 1) ? PW + SH : AW + 1;
  localparam logic [EW-1:0] PC_X  = EW'(PAGE_COUNT);
  localparam logic [EW-1:0] LIMIT = EW'(PAGE_COUNT) << SH;
  localparam logic [EW-1:0] PB_M1 = EW'(PAGE_BYTES - 1);
  localparam logic [CW-1:0] CNT_MAX = '1;

  // Captured item
  bpfa_pkg::op_e  op_q;
  logic [AW-1:0]  a_q, e_q;

  // Range and pointer state
  logic [PW-1:0]  lo_q, hm1_q;
  logic [WAW-1:0] lw_q, hw_q, ptr_q;

  // Word processing
  logic [WW-1:0]  rdata_q, wdata_q;
  logic [WS:0]    pop_q;
  logic           hit_q;
  logic [IW-1:0]  pg_q;

  // Live result and counters
  bpfa_pkg::stat_e     stat_q;
  logic [AW-1:0]       paddr_q;
  logic [CW-1:0]       free_q, total_q;

  // Output register
  logic [1:0]          out_stat_q;
  logic [bpfa_pkg::PADDR_W-1:0] out_paddr_q;
  logic [CW-1:0]       out_free_q, out_total_q;

  logic [WW-1:0]  mem [NW];

  // Setup decode
  logic [EW-1:0] a_x, e_x, pg_a, first_r, last_r, hi_r, fin, cnt_l, hi_l;
  logic [EW-1:0] lo_x, hi_x, hm1_x;
  logic          skip, ign;
  bpfa_pkg::stat_e stat_init;
  logic [EW:0]   tot_sum, free_sum;

  always_comb begin
    a_x     = EW'(a_q);
    e_x     = EW'(e_q);
    pg_a    = a_x >> SH;
    first_r = (a_x + PB_M1) >> SH;
    last_r  = e_x >> SH;
    hi_r    = (last_r < PC_X) ? last_r : PC_X;
    fin     = (e_x > LIMIT) ? LIMIT : e_x;
    cnt_l   = (fin - a_x) >> SH;
    hi_l    = (fin + PB_M1) >> SH;
    ign     = 1'b0;
    skip    = 1'b0;
    lo_x    = '0;
    hi_x    = PC_X;
    stat_init = bpfa_pkg::ST_DONE;
    unique case (op_q)
      bpfa_pkg::OP_ALLOC: begin
        stat_init = bpfa_pkg::ST_OOM;
      end
      bpfa_pkg::OP_FREE: begin
        stat_init = bpfa_pkg::ST_IGNORED;
        skip = (a_q == '0) || (a_q[SH-1:0] != '0) || (pg_a >= PC_X);
        lo_x = pg_a;
        hi_x = pg_a + EW'(1);
      end
      bpfa_pkg::OP_RESERVE: begin
        ign  = (e_q <= a_q);
        skip = ign || (first_r >= hi_r);
        stat_init = ign ? bpfa_pkg::ST_IGNORED : bpfa_pkg::ST_DONE;
        lo_x = first_r;
        hi_x = hi_r;
      end
      bpfa_pkg::OP_RELEASE: begin
        ign  = (a_x >= LIMIT) || (fin <= a_x);
        skip = ign;
        stat_init = ign ? bpfa_pkg::ST_IGNORED : bpfa_pkg::ST_DONE;
        lo_x = pg_a;
        hi_x = hi_l;
      end
      default: stat_init = bpfa_pkg::ST_DONE;
    endcase
    hm1_x    = hi_x - EW'(1);
    tot_sum  = {1'b0, cnt_l} + (EW + 1)'(total_q);
    free_sum = {1'b0, cnt_l} + (EW + 1)'(free_q);
  end

  // Word mask and modify
  logic [WS-1:0] lo_off, hi_off, bit_idx;
  logic [WW-1:0] mask, zeros, low_bit, new_word;
  logic          hit;

  always_comb begin
    lo_off   = (ptr_q == lw_q) ? lo_q[WS-1:0] : '0;
    hi_off   = (ptr_q == hw_q) ? hm1_q[WS-1:0] : '1;
    mask     = ({WW{1'b1}} << lo_off) & ({WW{1'b1}} >> (WS'(WW - 1) - hi_off));
    zeros    = ~rdata_q & mask;
    low_bit  = zeros & (~zeros + WW'(1));
    bit_idx  = '0;
    for (int i = 0; i < WW; i++) begin
      if (low_bit[i]) bit_idx = bit_idx | WS'(i);
    end
    hit      = 1'b0;
    new_word = rdata_q;
    case (op_q)
      bpfa_pkg::OP_ALLOC: begin
        hit      = |zeros;
        new_word = rdata_q | low_bit;
      end
      bpfa_pkg::OP_FREE: begin
        hit      = |(rdata_q & mask);
        new_word = rdata_q & ~mask;
      end
      bpfa_pkg::OP_RESERVE: new_word = rdata_q | mask;
      default:              new_word = rdata_q & ~mask;
    endcase
  end

  // Bitmap memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) mem[ptr_q] <= '1;
    else if (cmd_i.wr) mem[ptr_q] <= wdata_q;
    if (cmd_i.rd) rdata_q <= mem[ptr_q];
  end

  // Word pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
    end else if (cmd_i.setup) begin
      ptr_q <= WAW'(lo_x >> WS);
    end else if (cmd_i.inc) begin
      ptr_q <= (ptr_q == WAW'(NW - 1)) ? '0 : ptr_q + WAW'(1);
    end
  end

  // Counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q  <= '0;
      total_q <= '0;
    end else if (cmd_i.setup && op_q == bpfa_pkg::OP_RELEASE && !ign) begin
      total_q <= (tot_sum > (EW + 1)'(CNT_MAX)) ? CNT_MAX : CW'(tot_sum);
      free_q  <= (free_sum > (EW + 1)'(CNT_MAX)) ? CNT_MAX : CW'(free_sum);
    end else if (cmd_i.wr) begin
      case (op_q)
        bpfa_pkg::OP_ALLOC:
          if (hit_q && free_q != '0) free_q <= free_q - CW'(1);
        bpfa_pkg::OP_FREE:
          if (hit_q && free_q != CNT_MAX) free_q <= free_q + CW'(1);
        bpfa_pkg::OP_RESERVE:
          free_q <= (free_q > CW'(pop_q)) ? free_q - CW'(pop_q) : '0;
        default: free_q <= free_q;
      endcase
    end
  end

  // Item capture, range setup, word processing, live result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= bpfa_pkg::op_e'(op_i);
      a_q  <= address_i;
      e_q  <= range_end_i;
    end
    if (cmd_i.setup) begin
      lo_q    <= PW'(lo_x);
      hm1_q   <= PW'(hm1_x);
      lw_q    <= WAW'(lo_x >> WS);
      hw_q    <= WAW'(hm1_x >> WS);
      stat_q  <= stat_init;
      paddr_q <= '0;
    end
    if (cmd_i.proc) begin
      wdata_q <= new_word;
      hit_q   <= hit;
      pop_q   <= (WS + 1)'($countones(mask & ~rdata_q));
      pg_q    <= IW'({ptr_q, bit_idx});
    end
    if (cmd_i.wr && hit_q && (op_q == bpfa_pkg::OP_ALLOC || op_q == bpfa_pkg::OP_FREE)) begin
      stat_q <= bpfa_pkg::ST_DONE;
      if (op_q == bpfa_pkg::OP_ALLOC) paddr_q <= AW'(EW'(pg_q) << SH);
    end
    if (cmd_i.res_load) begin
      out_stat_q  <= stat_q;
      out_paddr_q <= paddr_q[bpfa_pkg::PADDR_W-1:0];
      out_free_q  <= free_q;
      out_total_q <= total_q;
    end
  end

  always_comb begin
    sts_o.clr_last = (ptr_q == WAW'(NW - 1));
    sts_o.skip     = skip;
    sts_o.last     = (ptr_q == hw_q);
    sts_o.stop     = (op_q == bpfa_pkg::OP_ALLOC) && hit_q;
  end

  assign status_o       = out_stat_q;
  assign page_address_o = out_paddr_q;
  assign free_count_o   = out_free_q;
  assign total_count_o  = out_total_q;

endmodule
